// ----- hdl/cvcpi_pkg.sv -----
// shared types, constants and reset values of the cascaded voltage/current pi unit
`timescale 1ns / 1ps
`default_nettype none

package cvcpi_pkg;

	localparam int DATA_W    = 32;
	localparam int SUM_W     = DATA_W + 1;
	localparam int MUL_W     = 33;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int ACC_W     = 80;
	localparam int INTEG_W   = 48;
	localparam int RES_W     = 50;
	localparam int U_W       = 17;
	localparam int DUTY_W    = 16;
	localparam int CFG_IDX_W = 3;

	localparam logic signed [DATA_W-1:0] VOLT_INT_GAIN_RST = -32'sd19375372;
	localparam logic signed [DATA_W-1:0] VOLT_FB_GAIN_RST  = 32'sd16515;
	localparam logic signed [DATA_W-1:0] CURR_INT_GAIN_RST = -32'sd8623509;
	localparam logic signed [DATA_W-1:0] CURR_FB_GAIN_RST  = 32'sd2053;
	localparam logic signed [DATA_W-1:0] IREF_UPPER_RST    = 32'sd655360;
	localparam logic signed [DATA_W-1:0] IREF_LOWER_RST    = -32'sd655360;
	localparam logic        [DATA_W-1:0] SAMPLE_PERIOD_RST = 32'd42950;

	localparam logic [U_W-1:0] U_MAX = 17'd65536;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VOLT_INT_GAIN = 3'd0,
		REG_VOLT_FB_GAIN  = 3'd1,
		REG_CURR_INT_GAIN = 3'd2,
		REG_CURR_FB_GAIN  = 3'd3,
		REG_IREF_UPPER    = 3'd4,
		REG_IREF_LOWER    = 3'd5,
		REG_SAMPLE_PERIOD = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] volt_int_gain;
		logic signed [DATA_W-1:0] volt_fb_gain;
		logic signed [DATA_W-1:0] curr_int_gain;
		logic signed [DATA_W-1:0] curr_fb_gain;
		logic signed [DATA_W-1:0] iref_upper;
		logic signed [DATA_W-1:0] iref_lower;
		logic        [DATA_W-1:0] sample_period;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_SUM,
		OP_MDH,
		OP_MDL,
		OP_MFB,
		OP_INT,
		OP_MKH,
		OP_MKL,
		OP_KAC,
		OP_RES,
		OP_CLP
	} op_t;

	typedef struct packed {
		op_t  op;
		logic loop;
		logic capture;
		logic clear;
		logic load_out;
	} cmd_t;

endpackage

`default_nettype wire

// ----- hdl/cvcpi_dp.sv -----
// datapath: error, trapezoid integrator, shared multiplier, gain terms and clamps
`timescale 1ns / 1ps
`default_nettype none

module cvcpi_dp (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire cvcpi_pkg::cfg_t                       cfg,
	input  wire cvcpi_pkg::cmd_t                       cmd,
	input  wire logic signed [cvcpi_pkg::DATA_W-1:0]   current_meas,
	input  wire logic signed [cvcpi_pkg::DATA_W-1:0]   voltage_meas,
	input  wire logic signed [cvcpi_pkg::DATA_W-1:0]   voltage_ref,
	output logic             [cvcpi_pkg::DUTY_W-1:0]   duty,
	output logic signed      [cvcpi_pkg::DATA_W-1:0]   current_ref
);

	logic signed [cvcpi_pkg::DATA_W-1:0]  cm_q, vm_q, vr_q;
	logic signed [cvcpi_pkg::DATA_W-1:0]  volt_prev_q, curr_prev_q, iref_q;
	logic signed [cvcpi_pkg::INTEG_W-1:0] volt_integ_q, curr_integ_q, fb_q;
	logic signed [cvcpi_pkg::SUM_W-1:0]   s_q;
	logic signed [cvcpi_pkg::PROD_W-1:0]  prod_q;
	logic signed [cvcpi_pkg::ACC_W-1:0]   acc_q;
	logic signed [cvcpi_pkg::RES_W-1:0]   r_q;
	logic        [cvcpi_pkg::DUTY_W-1:0]  duty_q;
	logic signed [cvcpi_pkg::DATA_W-1:0]  cref_q;

	logic signed [cvcpi_pkg::DATA_W-1:0]  ref_sel, meas_sel, prev_sel, int_gain, fb_gain;
	logic signed [cvcpi_pkg::INTEG_W-1:0] integ_sel, integ_new;
	logic signed [cvcpi_pkg::SUM_W-1:0]   err_wide, sum_w;
	logic signed [cvcpi_pkg::DATA_W-1:0]  err_sat;
	logic signed [cvcpi_pkg::MUL_W-1:0]   mul_a, mul_b;
	logic signed [cvcpi_pkg::PROD_W-1:0]  prod;
	logic signed [cvcpi_pkg::RES_W-1:0]   int_sum, upper_w, lower_w;
	logic signed [cvcpi_pkg::DATA_W-1:0]  iref_clamp;
	logic        [cvcpi_pkg::U_W-1:0]     u_clamp;

	always_comb begin
		ref_sel   = cmd.loop ? iref_q : vr_q;
		meas_sel  = cmd.loop ? cm_q : vm_q;
		prev_sel  = cmd.loop ? curr_prev_q : volt_prev_q;
		integ_sel = cmd.loop ? curr_integ_q : volt_integ_q;
		int_gain  = cmd.loop ? cfg.curr_int_gain : cfg.volt_int_gain;
		fb_gain   = cmd.loop ? cfg.curr_fb_gain : cfg.volt_fb_gain;
	end

	// saturated error and trapezoid sum
	always_comb begin
		err_wide = cvcpi_pkg::SUM_W'(ref_sel) - cvcpi_pkg::SUM_W'(meas_sel);
		if (err_wide[cvcpi_pkg::SUM_W-1] != err_wide[cvcpi_pkg::DATA_W-1]) begin
			err_sat = err_wide[cvcpi_pkg::SUM_W-1] ? {1'b1, {(cvcpi_pkg::DATA_W-1){1'b0}}}
			                                       : {1'b0, {(cvcpi_pkg::DATA_W-1){1'b1}}};
		end else begin
			err_sat = err_wide[cvcpi_pkg::DATA_W-1:0];
		end
		sum_w = cvcpi_pkg::SUM_W'(err_sat) + cvcpi_pkg::SUM_W'(prev_sel);
	end

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			cvcpi_pkg::OP_MDH: begin
				mul_a = s_q;
				mul_b = $signed({17'b0, cfg.sample_period[31:16]});
			end
			cvcpi_pkg::OP_MDL: begin
				mul_a = s_q;
				mul_b = $signed({17'b0, cfg.sample_period[15:0]});
			end
			cvcpi_pkg::OP_MFB: begin
				mul_a = cvcpi_pkg::MUL_W'(fb_gain);
				mul_b = cvcpi_pkg::MUL_W'(meas_sel);
			end
			cvcpi_pkg::OP_MKH: begin
				mul_a = cvcpi_pkg::MUL_W'(int_gain);
				mul_b = cvcpi_pkg::MUL_W'($signed(integ_sel[47:24]));
			end
			cvcpi_pkg::OP_MKL: begin
				mul_a = cvcpi_pkg::MUL_W'(int_gain);
				mul_b = $signed({9'b0, integ_sel[23:0]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = mul_a * mul_b;
	end

	// integrator add with saturation to 48 bits
	always_comb begin
		int_sum = cvcpi_pkg::RES_W'(integ_sel) + cvcpi_pkg::RES_W'(acc_q >>> 17);
		if (int_sum[49:47] == 3'b000 || int_sum[49:47] == 3'b111) begin
			integ_new = int_sum[cvcpi_pkg::INTEG_W-1:0];
		end else if (int_sum[49]) begin
			integ_new = {1'b1, {(cvcpi_pkg::INTEG_W-1){1'b0}}};
		end else begin
			integ_new = {1'b0, {(cvcpi_pkg::INTEG_W-1){1'b1}}};
		end
	end

	// clamps, upper limit tested first
	always_comb begin
		upper_w = cvcpi_pkg::RES_W'(cfg.iref_upper);
		lower_w = cvcpi_pkg::RES_W'(cfg.iref_lower);
		if (r_q > upper_w) begin
			iref_clamp = cfg.iref_upper;
		end else if (r_q < lower_w) begin
			iref_clamp = cfg.iref_lower;
		end else begin
			iref_clamp = r_q[cvcpi_pkg::DATA_W-1:0];
		end
		if (r_q > $signed({33'b0, cvcpi_pkg::U_MAX})) begin
			u_clamp = cvcpi_pkg::U_MAX;
		end else if (r_q[cvcpi_pkg::RES_W-1]) begin
			u_clamp = '0;
		end else begin
			u_clamp = r_q[cvcpi_pkg::U_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			volt_integ_q <= '0;
			curr_integ_q <= '0;
			volt_prev_q  <= '0;
			curr_prev_q  <= '0;
		end else if (cmd.clear) begin
			volt_integ_q <= '0;
			curr_integ_q <= '0;
			volt_prev_q  <= '0;
			curr_prev_q  <= '0;
		end else if (cmd.op == cvcpi_pkg::OP_SUM) begin
			if (cmd.loop) curr_prev_q <= err_sat;
			else          volt_prev_q <= err_sat;
		end else if (cmd.op == cvcpi_pkg::OP_INT) begin
			if (cmd.loop) curr_integ_q <= integ_new;
			else          volt_integ_q <= integ_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cm_q <= current_meas;
			vm_q <= voltage_meas;
			vr_q <= voltage_ref;
		end
		case (cmd.op)
			cvcpi_pkg::OP_SUM: s_q <= sum_w;
			cvcpi_pkg::OP_MDH: prod_q <= prod;
			cvcpi_pkg::OP_MDL: begin
				prod_q <= prod;
				acc_q  <= cvcpi_pkg::ACC_W'(prod_q) <<< 16;
			end
			cvcpi_pkg::OP_MFB: begin
				prod_q <= prod;
				acc_q  <= acc_q + cvcpi_pkg::ACC_W'(prod_q);
			end
			cvcpi_pkg::OP_INT: fb_q <= $signed(prod_q[63:16]);
			cvcpi_pkg::OP_MKH: prod_q <= prod;
			cvcpi_pkg::OP_MKL: begin
				prod_q <= prod;
				acc_q  <= cvcpi_pkg::ACC_W'(prod_q) <<< 24;
			end
			cvcpi_pkg::OP_KAC: acc_q <= acc_q + cvcpi_pkg::ACC_W'(prod_q);
			cvcpi_pkg::OP_RES: begin
				r_q <= -cvcpi_pkg::RES_W'($signed(acc_q[79:32])) - cvcpi_pkg::RES_W'(fb_q);
			end
			cvcpi_pkg::OP_CLP: begin
				if (!cmd.loop) iref_q <= iref_clamp;
			end
			default: begin
			end
		endcase
		if (cmd.load_out) begin
			duty_q <= u_clamp[cvcpi_pkg::U_W-1:1];
			cref_q <= iref_q;
		end
	end

	assign duty        = duty_q;
	assign current_ref = cref_q;

endmodule

`default_nettype wire

// ----- hdl/cvcpi_ctrl.sv -----
// controller: step sequencer for both loops and the result word handshake
`timescale 1ns / 1ps
`default_nettype none

module cvcpi_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cmd_valid,
	output logic                 cmd_stall,
	input  wire logic            action,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output cvcpi_pkg::cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_SUM,
		S_MDH,
		S_MDL,
		S_MFB,
		S_INT,
		S_MKH,
		S_MKL,
		S_KAC,
		S_RES,
		S_CLP
	} state_t;

	state_t state_q;
	logic   loop_q;
	logic   rsp_valid_q;
	logic   out_free;
	logic   accept;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd.loop     = loop_q;
		cmd.capture  = accept;
		cmd.clear    = accept && action;
		cmd.load_out = (state_q == S_CLP) && loop_q && out_free;
		case (state_q)
			S_SUM:   cmd.op = cvcpi_pkg::OP_SUM;
			S_MDH:   cmd.op = cvcpi_pkg::OP_MDH;
			S_MDL:   cmd.op = cvcpi_pkg::OP_MDL;
			S_MFB:   cmd.op = cvcpi_pkg::OP_MFB;
			S_INT:   cmd.op = cvcpi_pkg::OP_INT;
			S_MKH:   cmd.op = cvcpi_pkg::OP_MKH;
			S_MKL:   cmd.op = cvcpi_pkg::OP_MKL;
			S_KAC:   cmd.op = cvcpi_pkg::OP_KAC;
			S_RES:   cmd.op = cvcpi_pkg::OP_RES;
			S_CLP:   cmd.op = cvcpi_pkg::OP_CLP;
			default: cmd.op = cvcpi_pkg::OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			loop_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && !action) begin
						state_q <= S_SUM;
						loop_q  <= 1'b0;
					end
				end
				S_SUM: state_q <= S_MDH;
				S_MDH: state_q <= S_MDL;
				S_MDL: state_q <= S_MFB;
				S_MFB: state_q <= S_INT;
				S_INT: state_q <= S_MKH;
				S_MKH: state_q <= S_MKL;
				S_MKL: state_q <= S_KAC;
				S_KAC: state_q <= S_RES;
				S_RES: state_q <= S_CLP;
				S_CLP: begin
					if (!loop_q) begin
						loop_q  <= 1'b1;
						state_q <= S_SUM;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- hdl/cascaded_voltage_current_pi_unit.sv -----
// top level: configuration registers, controller and datapath of the cascaded pi unit
// run word: busy through both loops, rsp_valid rises on the return to idle, where the next word is taken
// first-entry word: clears both integrators at acceptance, no result, next word can follow in the next cycle
// the run is paced by one shared 33x33 multiplier, ten sequencer steps per loop, two loops
// a finished result waits in the output register while the next word is accepted
// reset clears integrators, previous errors and handshake state, gains return to defaults
`timescale 1ns / 1ps
`default_nettype none

module cascaded_voltage_current_pi_unit (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    cmd_valid,
	output logic                                         cmd_stall,
	input  wire logic                                    action,
	input  wire logic signed [cvcpi_pkg::DATA_W-1:0]     current_meas,
	input  wire logic signed [cvcpi_pkg::DATA_W-1:0]     voltage_meas,
	input  wire logic signed [cvcpi_pkg::DATA_W-1:0]     voltage_ref,
	output logic                                         rsp_valid,
	input  wire logic                                    rsp_stall,
	output logic             [cvcpi_pkg::DUTY_W-1:0]     duty,
	output logic signed      [cvcpi_pkg::DATA_W-1:0]     current_ref,
	input  wire logic                                    cfg_wr_en,
	input  wire logic        [cvcpi_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic        [cvcpi_pkg::DATA_W-1:0]     cfg_data
);

	cvcpi_pkg::cfg_t cfg_q;
	cvcpi_pkg::cmd_t cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.volt_int_gain <= cvcpi_pkg::VOLT_INT_GAIN_RST;
			cfg_q.volt_fb_gain  <= cvcpi_pkg::VOLT_FB_GAIN_RST;
			cfg_q.curr_int_gain <= cvcpi_pkg::CURR_INT_GAIN_RST;
			cfg_q.curr_fb_gain  <= cvcpi_pkg::CURR_FB_GAIN_RST;
			cfg_q.iref_upper    <= cvcpi_pkg::IREF_UPPER_RST;
			cfg_q.iref_lower    <= cvcpi_pkg::IREF_LOWER_RST;
			cfg_q.sample_period <= cvcpi_pkg::SAMPLE_PERIOD_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				cvcpi_pkg::REG_VOLT_INT_GAIN: cfg_q.volt_int_gain <= $signed(cfg_data);
				cvcpi_pkg::REG_VOLT_FB_GAIN:  cfg_q.volt_fb_gain  <= $signed(cfg_data);
				cvcpi_pkg::REG_CURR_INT_GAIN: cfg_q.curr_int_gain <= $signed(cfg_data);
				cvcpi_pkg::REG_CURR_FB_GAIN:  cfg_q.curr_fb_gain  <= $signed(cfg_data);
				cvcpi_pkg::REG_IREF_UPPER:    cfg_q.iref_upper    <= $signed(cfg_data);
				cvcpi_pkg::REG_IREF_LOWER:    cfg_q.iref_lower    <= $signed(cfg_data);
				cvcpi_pkg::REG_SAMPLE_PERIOD: cfg_q.sample_period <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	cvcpi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.action    (action),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd)
	);

	cvcpi_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.current_meas (current_meas),
		.voltage_meas (voltage_meas),
		.voltage_ref  (voltage_ref),
		.duty         (duty),
		.current_ref  (current_ref)
	);

	// first entry leaves the unit ready in the next cycle
	a_clear_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && action |=> !cmd_stall)
		else $error("first-entry word left the unit busy");

	// a run word keeps the unit busy
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall && !action |=> cmd_stall)
		else $error("run word did not start the sequencer");

	// a new result appears together with the return to idle
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !cmd_stall)
		else $error("result raised while sequencer still busy");

	// duty never exceeds one in q1.15
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> duty <= 16'd32768)
		else $error("duty out of range");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// testbench for the cascaded voltage/current pi unit: predicts every result word and checks it
`timescale 1ns / 1ps

module tb;
	import cvcpi_pkg::*;

	localparam int LIMIT_CYCLES = 600000;
	localparam int QUIET_PAD    = 30;
	localparam int HOLD_CYCLES  = 400;
	localparam int PHASE_WORDS  = 315;

	localparam logic [CFG_IDX_W-1:0]      REG_UNUSED = 3'd7;
	localparam logic signed [DATA_W-1:0]  S32_MAX    = 32'sh7fffffff;
	localparam logic signed [DATA_W-1:0]  S32_MIN    = 32'sh80000000;
	localparam logic signed [INTEG_W-1:0] I48_MAX    = {1'b0, {(INTEG_W-1){1'b1}}};
	localparam logic signed [INTEG_W-1:0] I48_MIN    = {1'b1, {(INTEG_W-1){1'b0}}};
	localparam logic signed [63:0]        DUTY_FULL  = 64'sd65536;
	localparam logic signed [DATA_W-1:0]  VREF_NOM   = 32'sd786432;

	localparam cfg_t DEFAULT_CFG = '{
		volt_int_gain: VOLT_INT_GAIN_RST,
		volt_fb_gain:  VOLT_FB_GAIN_RST,
		curr_int_gain: CURR_INT_GAIN_RST,
		curr_fb_gain:  CURR_FB_GAIN_RST,
		iref_upper:    IREF_UPPER_RST,
		iref_lower:    IREF_LOWER_RST,
		sample_period: SAMPLE_PERIOD_RST
	};

	typedef struct packed {
		logic        [DUTY_W-1:0] duty;
		logic signed [DATA_W-1:0] current_ref;
	} result_t;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     cmd_valid    = 1'b0;
	logic                     cmd_stall;
	logic                     action       = 1'b0;
	logic signed [DATA_W-1:0] current_meas = '0;
	logic signed [DATA_W-1:0] voltage_meas = '0;
	logic signed [DATA_W-1:0] voltage_ref  = '0;
	logic                     rsp_valid;
	logic                     rsp_stall    = 1'b0;
	logic        [DUTY_W-1:0] duty;
	logic signed [DATA_W-1:0] current_ref;
	logic                     cfg_wr_en    = 1'b0;
	logic     [CFG_IDX_W-1:0] cfg_index    = '0;
	logic        [DATA_W-1:0] cfg_data     = '0;

	cfg_t                      model_cfg = DEFAULT_CFG;
	logic signed [INTEG_W-1:0] volt_integ = '0;
	logic signed [DATA_W-1:0]  volt_prev  = '0;
	logic signed [INTEG_W-1:0] curr_integ = '0;
	logic signed [DATA_W-1:0]  curr_prev  = '0;

	result_t pending_outputs[$];
	result_t oldest_result;
	int      error_count = 0;
	int      cycle_count = 0;
	bit      burst       = 1'b0;
	int      stall_hold  = 0;

	cascaded_voltage_current_pi_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.action       (action),
		.current_meas (current_meas),
		.voltage_meas (voltage_meas),
		.voltage_ref  (voltage_ref),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.duty         (duty),
		.current_ref  (current_ref),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [63:0] x);
		if (x > S32_MAX) return S32_MAX;
		if (x < S32_MIN) return S32_MIN;
		return x[DATA_W-1:0];
	endfunction

	// trapezoidal step: acc + floor((e + ep) * dt / 2^17), held to 48 bits
	function automatic logic signed [INTEG_W-1:0] integ_update(
		input logic signed [INTEG_W-1:0] acc,
		input logic signed [DATA_W-1:0]  e,
		input logic signed [DATA_W-1:0]  ep
	);
		logic signed [127:0] err_sum;
		logic signed [127:0] r;
		err_sum = e;
		err_sum = err_sum + ep;
		r = acc + ((err_sum * $signed({1'b0, model_cfg.sample_period})) >>> 17);
		if (r > I48_MAX) r = I48_MAX;
		else if (r < I48_MIN) r = I48_MIN;
		return r[INTEG_W-1:0];
	endfunction

	// floor(k * x / 2^shift)
	function automatic logic signed [63:0] gain_product(
		input logic signed [DATA_W-1:0]  k,
		input logic signed [INTEG_W-1:0] x,
		input int                        shift
	);
		logic signed [127:0] p;
		p = k * x;
		p = p >>> shift;
		return p[63:0];
	endfunction

	function automatic result_t control_step(
		input logic signed [DATA_W-1:0] im,
		input logic signed [DATA_W-1:0] vm,
		input logic signed [DATA_W-1:0] vr
	);
		logic signed [63:0]       diff;
		logic signed [63:0]       iref;
		logic signed [63:0]       u;
		logic signed [DATA_W-1:0] ev;
		logic signed [DATA_W-1:0] ei;
		result_t                  r;
		diff = vr;
		diff = diff - vm;
		ev = sat_word(diff);
		volt_integ = integ_update(volt_integ, ev, volt_prev);
		volt_prev = ev;
		iref = -gain_product($signed(model_cfg.volt_int_gain), volt_integ, 32)
			- gain_product($signed(model_cfg.volt_fb_gain), vm, 16);
		if (iref > $signed(model_cfg.iref_upper)) iref = $signed(model_cfg.iref_upper);
		else if (iref < $signed(model_cfg.iref_lower)) iref = $signed(model_cfg.iref_lower);
		diff = iref - im;
		ei = sat_word(diff);
		curr_integ = integ_update(curr_integ, ei, curr_prev);
		curr_prev = ei;
		u = -gain_product($signed(model_cfg.curr_int_gain), curr_integ, 32)
			- gain_product($signed(model_cfg.curr_fb_gain), im, 16);
		if (u > DUTY_FULL) u = DUTY_FULL;
		else if (u < 0) u = 0;
		r.duty = u[DUTY_W:1];
		r.current_ref = iref[DATA_W-1:0];
		return r;
	endfunction

	// predict at acceptance of each command word
	always @(posedge clk) begin
		if (arst_n && cmd_valid && !cmd_stall) begin
			if (action) begin
				volt_integ = '0;
				volt_prev = '0;
				curr_integ = '0;
				curr_prev = '0;
			end else begin
				pending_outputs.push_back(control_step(current_meas, voltage_meas, voltage_ref));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_outputs.size() == 0) begin
				$error("unexpected result word: duty %0d current_ref %0d", duty, current_ref);
				error_count++;
			end else begin
				oldest_result = pending_outputs.pop_front();
				if (duty !== oldest_result.duty) begin
					$error("duty: expected %0d, actual %0d", oldest_result.duty, duty);
					error_count++;
				end
				if (current_ref !== oldest_result.current_ref) begin
					$error("current_ref: expected %0d, actual %0d",
						oldest_result.current_ref, current_ref);
					error_count++;
				end
			end
		end
	end

	// result side stall pattern
	initial begin : receiver
		int wait_n;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (stall_hold > 0) begin
				wait_n = stall_hold;
				stall_hold = 0;
			end else begin
				wait_n = burst ? 0 : $urandom_range(0, 13);
			end
			if (wait_n > 0) begin
				rsp_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
		end
	end

	initial begin : watchdog
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: done, errors");
		$finish;
	end

	task automatic send_word(
		input logic              act,
		input logic [DATA_W-1:0] im,
		input logic [DATA_W-1:0] vm,
		input logic [DATA_W-1:0] vr
	);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid    <= 1'b1;
		action       <= act;
		current_meas <= im;
		voltage_meas <= vm;
		voltage_ref  <= vr;
		do @(posedge clk); while (cmd_stall);
	endtask

	// drain every pending result, then let the pipeline settle
	task automatic wait_quiet();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending_outputs.size() != 0);
		repeat (QUIET_PAD) @(posedge clk);
	endtask

	task automatic load_cfg(input cfg_t c);
		for (int i = 0; i <= REG_SAMPLE_PERIOD; i++) begin
			cfg_wr_en <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			case (reg_idx_t'(i))
				REG_VOLT_INT_GAIN: cfg_data <= c.volt_int_gain;
				REG_VOLT_FB_GAIN:  cfg_data <= c.volt_fb_gain;
				REG_CURR_INT_GAIN: cfg_data <= c.curr_int_gain;
				REG_CURR_FB_GAIN:  cfg_data <= c.curr_fb_gain;
				REG_IREF_UPPER:    cfg_data <= c.iref_upper;
				REG_IREF_LOWER:    cfg_data <= c.iref_lower;
				REG_SAMPLE_PERIOD: cfg_data <= c.sample_period;
				default:           cfg_data <= '0;
			endcase
			@(posedge clk);
		end
		// unmapped index must be ignored
		cfg_index <= REG_UNUSED;
		cfg_data  <= $urandom;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		model_cfg = c;
	endtask

	function automatic logic [DATA_W-1:0] rand_span(input int bits);
		return int'($urandom_range(0, 2 ** (bits + 1))) - (2 ** bits);
	endfunction

	function automatic logic [DATA_W-1:0] rand_signal();
		case ($urandom_range(0, 5))
			0:       return $urandom;
			1:       return ($urandom_range(0, 1) == 0) ? S32_MAX : S32_MIN;
			default: return rand_span(20);
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_rail();
		return ($urandom_range(0, 1) == 0) ? S32_MAX : S32_MIN;
	endfunction

	function automatic cfg_t moderate_cfg();
		cfg_t c;
		c.volt_int_gain = -int'($urandom_range(0, 1 << 26));
		c.volt_fb_gain  = $urandom_range(0, 1 << 16);
		c.curr_int_gain = -int'($urandom_range(0, 1 << 25));
		c.curr_fb_gain  = rand_span(12);
		c.iref_upper    = $urandom_range(1 << 16, 1 << 22);
		c.iref_lower    = -c.iref_upper;
		c.sample_period = $urandom_range(1, 1 << 20);
		return c;
	endfunction

	function automatic cfg_t extreme_cfg();
		cfg_t c;
		c.volt_int_gain = rand_rail();
		c.volt_fb_gain  = rand_rail();
		c.curr_int_gain = rand_rail();
		c.curr_fb_gain  = rand_rail();
		c.iref_upper    = S32_MAX;
		c.iref_lower    = S32_MIN;
		c.sample_period = 32'hffffffff;
		return c;
	endfunction

	task automatic test_first_entry_defaults();
		send_word(1'b1, $urandom, $urandom, $urandom);
		send_word(1'b0, '0, '0, '0);
		send_word(1'b0, S32_MAX, S32_MAX, S32_MAX);
		send_word(1'b0, S32_MIN, S32_MIN, S32_MIN);
		send_word(1'b0, 32'sd65536, 32'sd720896, VREF_NOM);
		send_word(1'b0, 32'sd65536, 32'sd720896, VREF_NOM);
		send_word(1'b1, $urandom, $urandom, $urandom);
		send_word(1'b0, -32'sd65536, 32'sd851968, VREF_NOM);
	endtask

	task automatic test_integrator_saturation();
		wait_quiet();
		load_cfg(extreme_cfg());
		repeat (3) send_word(1'b0, S32_MIN, S32_MIN, S32_MAX);
		repeat (3) send_word(1'b0, S32_MAX, S32_MAX, S32_MIN);
		send_word(1'b1, '0, '0, '0);
		send_word(1'b0, S32_MIN, S32_MAX, S32_MAX);
	endtask

	task automatic test_crossed_limits();
		cfg_t c;
		c = DEFAULT_CFG;
		c.iref_upper = -32'sd655360;
		c.iref_lower = 32'sd655360;
		wait_quiet();
		load_cfg(c);
		send_word(1'b0, '0, S32_MIN, '0);
		send_word(1'b0, '0, S32_MAX, '0);
		send_word(1'b0, '0, '0, '0);
		send_word(1'b0, 32'sd65536, VREF_NOM, VREF_NOM);
	endtask

	// receiver holds off while the sender keeps offering words
	task automatic test_backpressure();
		wait_quiet();
		load_cfg(moderate_cfg());
		burst = 1'b1;
		stall_hold = HOLD_CYCLES;
		repeat (24) send_word(1'b0, rand_span(18), VREF_NOM + rand_span(15), VREF_NOM);
		burst = 1'b0;
	endtask

	task automatic random_phase(input cfg_t c);
		int                       k;
		logic signed [DATA_W-1:0] vr;
		wait_quiet();
		load_cfg(c);
		for (int n = 0; n < PHASE_WORDS; n++) begin
			if (n % 50 == 0) burst = ($urandom_range(0, 3) == 0);
			k = $urandom_range(0, 99);
			if (k < 3) begin
				send_word(1'b1, $urandom, $urandom, $urandom);
			end else if (k < 15) begin
				send_word(1'b0, rand_signal(), rand_signal(), rand_signal());
			end else begin
				vr = VREF_NOM + rand_span(16);
				send_word(1'b0, rand_span(18), vr + rand_span(15), vr);
			end
		end
		burst = 1'b0;
	endtask

	task automatic test_random();
		cfg_t c;
		random_phase(moderate_cfg());
		c = moderate_cfg();
		c.sample_period = $urandom_range(1, 1 << 12);
		random_phase(c);
		c.volt_int_gain = $urandom;
		c.volt_fb_gain  = $urandom;
		c.curr_int_gain = $urandom;
		c.curr_fb_gain  = $urandom;
		c.iref_upper    = $urandom;
		c.iref_lower    = $urandom;
		c.sample_period = $urandom;
		random_phase(c);
		random_phase(extreme_cfg());
		c = moderate_cfg();
		c.iref_lower = c.iref_upper;
		c.iref_upper = -c.iref_upper;
		c.sample_period = '0;
		random_phase(c);
		random_phase(DEFAULT_CFG);
	endtask

	initial begin : main
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_first_entry_defaults();
		test_integrator_saturation();
		test_crossed_limits();
		test_backpressure();
		test_random();
		wait_quiet();
		if (error_count == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
